// ----- design/ludpp_pkg.sv -----
// ----------------------------------------------------------------------------
// ludpp_pkg
// Shared codes, controller states, datapath commands and saturation helpers
// for the LU decomposition unit.
// ----------------------------------------------------------------------------
package ludpp_pkg;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_RUN   = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  localparam logic [1:0] SEL_LOWER = 2'd0;
  localparam logic [1:0] SEL_UPPER = 2'd1;
  localparam logic [1:0] SEL_PERM  = 2'd2;

  localparam logic [31:0] ONE_Q   = 32'h0001_0000;
  localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;

  typedef enum logic [5:0] {
    ST_IDLE, ST_RD_WAIT, ST_RD_DONE, ST_RUN_INIT,
    ST_PV_START, ST_PV_RD, ST_PV_CMP, ST_PV_END,
    ST_SW_RD_I, ST_SW_RD_G, ST_SW_WR_I, ST_SW_WR_G,
    ST_LS_RD_I, ST_LS_RD_G, ST_LS_WR_I, ST_LS_WR_G,
    ST_PS_A, ST_PS_B, ST_PS_C,
    ST_LD_START, ST_LD_RD, ST_LD_WR,
    ST_EL_START, ST_EL_RD, ST_EL_CHK, ST_EL_DIV, ST_EL_WR,
    ST_EM_RD, ST_EM_MUL, ST_EM_SUB, ST_EL_NEXT, ST_COL_NEXT, ST_FINISH
  } ludpp_state_e;

  typedef enum logic [5:0] {
    CMD_NONE, CMD_ACCEPT, CMD_RD_OUT, CMD_RUN_INIT,
    CMD_PV_START, CMD_PV_RD, CMD_PV_CMP,
    CMD_SW_RD_I, CMD_SW_RD_G, CMD_SW_WR_I, CMD_SW_WR_G,
    CMD_LS_RD_I, CMD_LS_RD_G, CMD_LS_WR_I, CMD_LS_WR_G,
    CMD_PS_A, CMD_PS_B, CMD_PS_C,
    CMD_LD_START, CMD_LD_RD, CMD_LD_WR,
    CMD_EL_START, CMD_EL_RD, CMD_EL_CHK, CMD_EL_DIV, CMD_EL_WR,
    CMD_EM_RD, CMD_EM_MUL, CMD_EM_SUB, CMD_EL_NEXT, CMD_COL_NEXT, CMD_FIN_OUT
  } ludpp_cmd_e;

  typedef struct packed {
    logic swap_needed;
    logic i_zero;
    logic j_last;
    logic k_last;
    logic k_last_left;
    logic col_last;
    logic skip_elim;
    logic div_done;
  } ludpp_stat_t;

  function automatic logic [31:0] sat48(input logic signed [47:0] v);
    logic [31:0] r;
    if (v > $signed({16'h0000, SAT_MAX})) r = SAT_MAX;
    else if (v < $signed({16'hFFFF, SAT_MIN})) r = SAT_MIN;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [31:0] sat33(input logic signed [32:0] v);
    logic [31:0] r;
    if (v[32] != v[31]) r = v[32] ? SAT_MIN : SAT_MAX;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ----- design/ludpp_div.sv -----
// ----------------------------------------------------------------------------
// ludpp_div
// Radix-2 restoring divider for Q16.16 quotients, one bit per cycle,
// truncating toward zero and saturating to 32 bits.
// ----------------------------------------------------------------------------
module ludpp_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [31:0] quot_o
);
  import ludpp_pkg::*;

  logic        busy_q, done_q, neg_q;
  logic [5:0]  cnt_q;
  logic [47:0] dvd_q;
  logic [31:0] dsr_q, rem_q;
  logic [31:0] num_mag, den_mag;
  logic [32:0] rem_sh;
  logic        ge;

  assign num_mag = num_i[31] ? (~num_i + 32'd1) : num_i;
  assign den_mag = den_i[31] ? (~den_i + 32'd1) : den_i;
  assign rem_sh  = {rem_q, dvd_q[47]};
  assign ge      = rem_sh >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd47) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // The quotient bits shift into the low end of the dividend register.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= {num_mag, 16'h0000};
      dsr_q <= den_mag;
      rem_q <= '0;
      neg_q <= num_i[31] ^ den_i[31];
    end else if (busy_q) begin
      rem_q <= ge ? 32'(rem_sh - {1'b0, dsr_q}) : rem_sh[31:0];
      dvd_q <= {dvd_q[46:0], ge};
    end
  end

  always_comb begin
    if (!neg_q) begin
      quot_o = (dvd_q > 48'h0000_7FFF_FFFF) ? SAT_MAX : dvd_q[31:0];
    end else begin
      quot_o = (dvd_q > 48'h0000_8000_0000) ? SAT_MIN : (~dvd_q[31:0] + 32'd1);
    end
  end

  assign done_o = done_q;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider started while busy");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q) else $error("divider did not start");
  a_done_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($past(busy_q) && !busy_q)) else $error("done without a division");
`endif

endmodule

// ----- design/ludpp_ctrl.sv -----
// ----------------------------------------------------------------------------
// ludpp_ctrl
// Sequencer for accepting transactions, reads and the pivoted elimination.
// ----------------------------------------------------------------------------
module ludpp_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic [1:0]             func_i,
  input  logic                   out_stall_i,
  input  ludpp_pkg::ludpp_stat_t stat_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  output ludpp_pkg::ludpp_cmd_e  cmd_o
);
  import ludpp_pkg::*;

  ludpp_state_e state_q, state_d;
  logic         out_valid_q, out_valid_d;
  logic         accept, slot_free;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign slot_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (func_i == FUNC_RUN) state_d = ST_RUN_INIT;
          else if (func_i == FUNC_READ) state_d = ST_RD_WAIT;
        end
      end
      ST_RD_WAIT:  state_d = ST_RD_DONE;
      ST_RD_DONE:  if (slot_free) state_d = ST_IDLE;
      ST_RUN_INIT: state_d = ST_PV_START;
      ST_PV_START: state_d = ST_PV_RD;
      ST_PV_RD:    state_d = ST_PV_CMP;
      ST_PV_CMP:   state_d = stat_i.j_last ? ST_PV_END : ST_PV_RD;
      ST_PV_END:   state_d = stat_i.swap_needed ? ST_SW_RD_I : ST_LD_START;
      ST_SW_RD_I:  state_d = ST_SW_RD_G;
      ST_SW_RD_G:  state_d = ST_SW_WR_I;
      ST_SW_WR_I:  state_d = ST_SW_WR_G;
      ST_SW_WR_G: begin
        if (!stat_i.k_last) state_d = ST_SW_RD_I;
        else state_d = stat_i.i_zero ? ST_PS_A : ST_LS_RD_I;
      end
      ST_LS_RD_I:  state_d = ST_LS_RD_G;
      ST_LS_RD_G:  state_d = ST_LS_WR_I;
      ST_LS_WR_I:  state_d = ST_LS_WR_G;
      ST_LS_WR_G:  state_d = stat_i.k_last_left ? ST_PS_A : ST_LS_RD_I;
      ST_PS_A:     state_d = ST_PS_B;
      ST_PS_B:     state_d = ST_PS_C;
      ST_PS_C:     state_d = ST_LD_START;
      ST_LD_START: state_d = ST_LD_RD;
      ST_LD_RD:    state_d = ST_LD_WR;
      ST_LD_WR:    state_d = stat_i.k_last ? ST_EL_START : ST_LD_RD;
      ST_EL_START: state_d = ST_EL_RD;
      ST_EL_RD:    state_d = ST_EL_CHK;
      ST_EL_CHK:   state_d = stat_i.skip_elim ? ST_EL_NEXT : ST_EL_DIV;
      ST_EL_DIV:   if (stat_i.div_done) state_d = ST_EL_WR;
      ST_EL_WR:    state_d = ST_EM_RD;
      ST_EM_RD:    state_d = ST_EM_MUL;
      ST_EM_MUL:   state_d = ST_EM_SUB;
      ST_EM_SUB:   state_d = stat_i.k_last ? ST_EL_NEXT : ST_EM_RD;
      ST_EL_NEXT:  state_d = stat_i.j_last ? ST_COL_NEXT : ST_EL_RD;
      ST_COL_NEXT: state_d = stat_i.col_last ? ST_FINISH : ST_PV_START;
      ST_FINISH:   if (slot_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = CMD_NONE;
    case (state_q)
      ST_IDLE:     if (accept) cmd_o = CMD_ACCEPT;
      ST_RD_DONE:  if (slot_free) cmd_o = CMD_RD_OUT;
      ST_RUN_INIT: cmd_o = CMD_RUN_INIT;
      ST_PV_START: cmd_o = CMD_PV_START;
      ST_PV_RD:    cmd_o = CMD_PV_RD;
      ST_PV_CMP:   cmd_o = CMD_PV_CMP;
      ST_SW_RD_I:  cmd_o = CMD_SW_RD_I;
      ST_SW_RD_G:  cmd_o = CMD_SW_RD_G;
      ST_SW_WR_I:  cmd_o = CMD_SW_WR_I;
      ST_SW_WR_G:  cmd_o = CMD_SW_WR_G;
      ST_LS_RD_I:  cmd_o = CMD_LS_RD_I;
      ST_LS_RD_G:  cmd_o = CMD_LS_RD_G;
      ST_LS_WR_I:  cmd_o = CMD_LS_WR_I;
      ST_LS_WR_G:  cmd_o = CMD_LS_WR_G;
      ST_PS_A:     cmd_o = CMD_PS_A;
      ST_PS_B:     cmd_o = CMD_PS_B;
      ST_PS_C:     cmd_o = CMD_PS_C;
      ST_LD_START: cmd_o = CMD_LD_START;
      ST_LD_RD:    cmd_o = CMD_LD_RD;
      ST_LD_WR:    cmd_o = CMD_LD_WR;
      ST_EL_START: cmd_o = CMD_EL_START;
      ST_EL_RD:    cmd_o = CMD_EL_RD;
      ST_EL_CHK:   cmd_o = CMD_EL_CHK;
      ST_EL_DIV:   cmd_o = CMD_EL_DIV;
      ST_EL_WR:    cmd_o = CMD_EL_WR;
      ST_EM_RD:    cmd_o = CMD_EM_RD;
      ST_EM_MUL:   cmd_o = CMD_EM_MUL;
      ST_EM_SUB:   cmd_o = CMD_EM_SUB;
      ST_EL_NEXT:  cmd_o = CMD_EL_NEXT;
      ST_COL_NEXT: cmd_o = CMD_COL_NEXT;
      ST_FINISH:   if (slot_free) cmd_o = CMD_FIN_OUT;
      default:     cmd_o = CMD_NONE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o == CMD_RD_OUT || cmd_o == CMD_FIN_OUT) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EL_DIV && !stat_i.div_done) |=> state_q == ST_EL_DIV)
    else $error("left the divide wait early");
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_RD_DONE || $past(state_q) == ST_FINISH))
    else $error("result without a read or run");
  a_run_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && func_i == FUNC_RUN) |=> state_q == ST_RUN_INIT)
    else $error("run transaction not started");
`endif

endmodule

// ----- design/ludpp_dpath.sv -----
// ----------------------------------------------------------------------------
// ludpp_dpath
// Matrix stores, loop counters, pivot row buffer, permutation, multiply,
// subtract and the quotient unit, driven one command per cycle.
// ----------------------------------------------------------------------------
module ludpp_dpath #(
  parameter int MAX_DIM = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ludpp_pkg::ludpp_cmd_e             cmd_i,
  input  logic [$clog2(MAX_DIM+1)-1:0]      n_use_i,
  input  logic [1:0]                        func_i,
  input  logic [1:0]                        matrix_sel_i,
  input  logic [3:0]                        row_index_i,
  input  logic [3:0]                        col_index_i,
  input  logic [31:0]                       entry_value_i,
  output ludpp_pkg::ludpp_stat_t            stat_o,
  output logic [31:0]                       result_value_o,
  output logic                              status_o
);
  import ludpp_pkg::*;

  localparam int IDX_W = $clog2(MAX_DIM);
  localparam int AW    = 2 * IDX_W;
  localparam int DEPTH = 1 << AW;
  localparam int N_W   = $clog2(MAX_DIM + 1);
  localparam int CMP_W = (N_W > 4) ? N_W : 4;

  logic [31:0] u_mem [DEPTH];
  logic [31:0] l_mem [DEPTH];
  logic [31:0] u_rd_q, l_rd_q;
  logic        u_we, l_we;
  logic [AW-1:0] u_waddr, u_raddr, l_waddr, l_raddr;
  logic [31:0] u_wdata, l_wdata;

  logic [IDX_W-1:0] i_q, j_q, k_q, g_q, ptmp_q, last_idx, last_m1;
  logic [IDX_W-1:0] perm_q [MAX_DIM];
  logic [IDX_W-1:0] perm_addr, perm_rd;
  logic [31:0]      row_buf_q [MAX_DIM];
  logic [32:0]      best_q, mag;
  logic [31:0]      tmp_q, q_q, ujk_q, result_q, piv, diff, read_val;
  logic signed [63:0] prod_q;
  logic [31:0]      prod_sat;
  logic [N_W-1:0]   nrun_q;
  logic             l_valid_q, status_q;
  logic [1:0]       req_sel_q;
  logic [3:0]       req_row_q, req_col_q;
  logic [IDX_W-1:0] rr, rc;
  logic             in_ok, req_ok;
  logic             div_start, div_done;
  logic [31:0]      div_quot;

  assign last_idx = IDX_W'(nrun_q - N_W'(1));
  assign last_m1  = IDX_W'(nrun_q - N_W'(2));
  assign piv      = row_buf_q[i_q];
  assign rr       = IDX_W'(req_row_q);
  assign rc       = IDX_W'(req_col_q);

  assign in_ok  = (CMP_W'(row_index_i) < CMP_W'(n_use_i)) &&
                  (CMP_W'(col_index_i) < CMP_W'(n_use_i));
  assign req_ok = (CMP_W'(req_row_q) < CMP_W'(n_use_i)) &&
                  (CMP_W'(req_col_q) < CMP_W'(n_use_i));

  // True magnitude, so the most negative value ranks highest.
  assign mag = u_rd_q[31] ? (~{1'b1, u_rd_q} + 33'd1) : {1'b0, u_rd_q};

  assign prod_sat = sat48(prod_q[63:16]);
  assign diff     = sat33($signed({ujk_q[31], ujk_q}) - $signed({prod_sat[31], prod_sat}));

  assign div_start = (cmd_i == CMD_EL_CHK) && !stat_o.skip_elim;

  ludpp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (u_rd_q),
    .den_i   (piv),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_comb begin
    stat_o.swap_needed = (g_q != i_q);
    stat_o.i_zero      = (i_q == '0);
    stat_o.j_last      = (j_q == last_idx);
    stat_o.k_last      = (k_q == last_idx);
    stat_o.k_last_left = (k_q == IDX_W'(i_q - IDX_W'(1)));
    stat_o.col_last    = (i_q == last_m1);
    stat_o.skip_elim   = (u_rd_q == '0) || (piv == '0);
    stat_o.div_done    = div_done;
  end

  // Store port selection.
  always_comb begin
    u_we    = 1'b0;
    u_waddr = {IDX_W'(row_index_i), IDX_W'(col_index_i)};
    u_wdata = entry_value_i;
    u_raddr = {rr, rc};
    l_we    = 1'b0;
    l_waddr = {j_q, i_q};
    l_wdata = '0;
    l_raddr = {rr, rc};
    perm_addr = rr;
    case (cmd_i)
      CMD_ACCEPT:  u_we = (func_i == FUNC_WRITE) && in_ok;
      CMD_PV_RD:   u_raddr = {j_q, i_q};
      CMD_SW_RD_I: u_raddr = {i_q, k_q};
      CMD_SW_RD_G: u_raddr = {g_q, k_q};
      CMD_SW_WR_I: begin
        u_we = 1'b1; u_waddr = {i_q, k_q}; u_wdata = u_rd_q;
      end
      CMD_SW_WR_G: begin
        u_we = 1'b1; u_waddr = {g_q, k_q}; u_wdata = tmp_q;
      end
      CMD_LS_RD_I: l_raddr = {i_q, k_q};
      CMD_LS_RD_G: l_raddr = {g_q, k_q};
      CMD_LS_WR_I: begin
        l_we = 1'b1; l_waddr = {i_q, k_q}; l_wdata = l_rd_q;
      end
      CMD_LS_WR_G: begin
        l_we = 1'b1; l_waddr = {g_q, k_q}; l_wdata = tmp_q;
      end
      CMD_PS_A:    perm_addr = i_q;
      CMD_PS_B:    perm_addr = g_q;
      CMD_LD_RD:   u_raddr = {i_q, k_q};
      CMD_EL_RD:   u_raddr = {j_q, i_q};
      CMD_EL_CHK:  l_we = stat_o.skip_elim;
      CMD_EL_WR: begin
        l_we = 1'b1; l_wdata = q_q;
        u_we = 1'b1; u_waddr = {j_q, i_q}; u_wdata = '0;
      end
      CMD_EM_RD:   u_raddr = {j_q, k_q};
      CMD_EM_SUB: begin
        u_we = 1'b1; u_waddr = {j_q, k_q}; u_wdata = diff;
      end
      default: ;
    endcase
  end

  assign perm_rd = perm_q[perm_addr];

  always_ff @(posedge clk_i) begin
    if (u_we) u_mem[u_waddr] <= u_wdata;
    u_rd_q <= u_mem[u_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (l_we) l_mem[l_waddr] <= l_wdata;
    l_rd_q <= l_mem[l_raddr];
  end

  // After a run, in-range L entries outside its multiplier region are identity.
  always_comb begin
    read_val = '0;
    if (req_ok) begin
      case (req_sel_q)
        SEL_LOWER: begin
          if (l_valid_q) begin
            if (rr == rc) read_val = ONE_Q;
            else if (rr > rc && N_W'(rc) < N_W'(nrun_q - N_W'(1)) && N_W'(rr) < nrun_q)
              read_val = l_rd_q;
          end
        end
        SEL_UPPER: read_val = u_rd_q;
        SEL_PERM:  read_val = (perm_rd == rc) ? ONE_Q : '0;
        default:   read_val = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l_valid_q <= 1'b0;
      nrun_q    <= N_W'(MAX_DIM);
      for (int r = 0; r < MAX_DIM; r++) perm_q[r] <= IDX_W'(r);
    end else begin
      case (cmd_i)
        CMD_RUN_INIT: begin
          l_valid_q <= 1'b1;
          nrun_q    <= n_use_i;
          for (int r = 0; r < MAX_DIM; r++) perm_q[r] <= IDX_W'(r);
        end
        CMD_PS_B: perm_q[i_q] <= perm_rd;
        CMD_PS_C: perm_q[g_q] <= ptmp_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_ACCEPT: begin
        req_sel_q <= matrix_sel_i;
        req_row_q <= row_index_i;
        req_col_q <= col_index_i;
      end
      CMD_RD_OUT: begin
        result_q <= read_val;
        status_q <= 1'b0;
      end
      CMD_FIN_OUT: begin
        result_q <= '0;
        status_q <= 1'b1;
      end
      CMD_RUN_INIT: i_q <= '0;
      CMD_PV_START: begin
        j_q <= i_q;
        g_q <= i_q;
      end
      CMD_PV_CMP: begin
        if (j_q == i_q || mag > best_q) begin
          best_q <= mag;
          g_q    <= j_q;
        end
        j_q <= j_q + IDX_W'(1);
        k_q <= '0;
      end
      CMD_SW_RD_G: tmp_q <= u_rd_q;
      CMD_SW_WR_G: k_q <= stat_o.k_last ? '0 : k_q + IDX_W'(1);
      CMD_LS_RD_G: tmp_q <= l_rd_q;
      CMD_LS_WR_G: k_q <= k_q + IDX_W'(1);
      CMD_PS_A:    ptmp_q <= perm_rd;
      CMD_LD_START: k_q <= i_q;
      CMD_LD_WR: begin
        row_buf_q[k_q] <= u_rd_q;
        k_q <= k_q + IDX_W'(1);
      end
      CMD_EL_START: j_q <= i_q + IDX_W'(1);
      CMD_EL_DIV:  if (div_done) q_q <= div_quot;
      CMD_EL_WR:   k_q <= i_q + IDX_W'(1);
      CMD_EM_MUL: begin
        ujk_q  <= u_rd_q;
        prod_q <= $signed(row_buf_q[k_q]) * $signed(q_q);
      end
      CMD_EM_SUB:  k_q <= k_q + IDX_W'(1);
      CMD_EL_NEXT: j_q <= j_q + IDX_W'(1);
      CMD_COL_NEXT: i_q <= i_q + IDX_W'(1);
      default: ;
    endcase
  end

  assign result_value_o = result_q;
  assign status_o       = status_q;

endmodule

// ----- design/lu_decompose_partial_pivot_unit.sv -----
// ----------------------------------------------------------------------------
// lu_decompose_partial_pivot_unit
// LU decomposition with partial pivoting on a square Q16.16 matrix.
// ----------------------------------------------------------------------------
// Write transactions store one entry of A. A read registers its request,
// reads one entry of L, U or P from the stores and presents it once the
// output slot is free. A run factors P*A = L*U in place and answers with
// status 1. Its time is set by the matrix stores, which move one element
// per step, and by the bit-serial divider, which runs once for each
// multiplier that is not skipped. No clearing pass is needed after reset.
// One transaction is worked at a time.
// ----------------------------------------------------------------------------
module lu_decompose_partial_pivot_unit #(
  parameter int MAX_DIM = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [1:0]  matrix_sel_i,
  input  logic [3:0]  row_index_i,
  input  logic [3:0]  col_index_i,
  input  logic [31:0] entry_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] result_value_o,
  output logic        status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i
);
  import ludpp_pkg::*;

  localparam int N_W  = $clog2(MAX_DIM + 1);
  localparam int SZ_W = (N_W > 5) ? N_W : 5;

  logic [4:0]     matrix_size_q;
  logic [N_W-1:0] n_use;
  ludpp_cmd_e     cmd;
  ludpp_stat_t    stat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matrix_size_q <= 5'd16;
    end else if (cfg_valid_i && cfg_ready_o) begin
      matrix_size_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (matrix_size_q < 5'd2) n_use = N_W'(2);
    else if (SZ_W'(matrix_size_q) > SZ_W'(MAX_DIM)) n_use = N_W'(MAX_DIM);
    else n_use = N_W'(matrix_size_q);
  end

  ludpp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .func_i      (func_i),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  ludpp_dpath #(
    .MAX_DIM (MAX_DIM)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .n_use_i        (n_use),
    .func_i         (func_i),
    .matrix_sel_i   (matrix_sel_i),
    .row_index_i    (row_index_i),
    .col_index_i    (col_index_i),
    .entry_value_i  (entry_value_i),
    .stat_o         (stat),
    .result_value_o (result_value_o),
    .status_o       (status_o)
  );

endmodule

// ----- verif/lu_decompose_partial_pivot_unit_test.sv -----
// ----------------------------------------------------------------------------
// lu_decompose_partial_pivot_unit_test
// Self-checking testbench for the LU decomposition unit. It loads matrices,
// runs the factorization and reads back L, U and P. A built-in predictor of
// the factorization produces the expected result of each read and run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lu_decompose_partial_pivot_unit_test;
  import ludpp_pkg::*;

  localparam int DIM = 16;
  localparam longint CYCLE_LIMIT = 2000000;
  localparam logic [1:0] FUNC_NOP = 2'd3;
  localparam logic [1:0] SEL_NONE = 2'd3;

  typedef struct packed {
    logic [31:0] value;
    logic        status;
  } lu_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  func_i = FUNC_WRITE;
  logic [1:0]  matrix_sel_i = SEL_LOWER;
  logic [3:0]  row_index_i = '0;
  logic [3:0]  col_index_i = '0;
  logic [31:0] entry_value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] result_value_o;
  logic        status_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [4:0]  cfg_data_i = '0;

  lu_decompose_partial_pivot_unit u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state.
  logic signed [31:0] upper_q [DIM*DIM];
  logic signed [31:0] lower_q [DIM*DIM];
  logic [3:0]         perm_q [DIM];
  bit                 written_q [DIM*DIM];
  logic [4:0]         size_reg;

  lu_result_t expected_results [$];
  int  mismatches = 0;
  bit  failed = 0;
  longint cycle_count = 0;
  int  hold_off = 0;
  int  stall_pct = 30;

  function automatic int dim_in_use();
    if (size_reg < 2) return 2;
    if (size_reg > DIM) return DIM;
    return size_reg;
  endfunction

  function automatic logic signed [31:0] clamp(input logic signed [65:0] v);
    if (v > 66'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -66'sh8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Product shifted right by 16, rounding toward minus infinity.
  function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    logic signed [65:0] p;
    p = 66'(a) * 66'(b);
    return clamp(p >>> 16);
  endfunction

  function automatic logic signed [31:0] fx_div(input logic signed [31:0] num,
                                                input logic signed [31:0] den);
    logic signed [65:0] n;
    n = 66'(num) <<< 16;
    return clamp(n / 66'(den));
  endfunction

  function automatic logic [32:0] mag(input logic signed [31:0] v);
    return v < 0 ? -33'(v) : 33'(v);
  endfunction

  task automatic factor_matrix();
    int n, g;
    logic [32:0] best;
    logic signed [31:0] t, piv, lead, q;
    logic [3:0] tp;
    n = dim_in_use();
    for (int a = 0; a < DIM*DIM; a++) lower_q[a] = 0;
    for (int a = 0; a < DIM; a++) begin
      lower_q[a*DIM+a] = ONE_Q;
      perm_q[a] = a[3:0];
    end
    for (int i = 0; i + 1 < n; i++) begin
      g = i;
      best = mag(upper_q[i*DIM+i]);
      for (int j = i + 1; j < n; j++)
        if (mag(upper_q[j*DIM+i]) > best) begin
          best = mag(upper_q[j*DIM+i]);
          g = j;
        end
      if (g != i) begin
        for (int k = 0; k < n; k++) begin
          t = upper_q[i*DIM+k];
          upper_q[i*DIM+k] = upper_q[g*DIM+k];
          upper_q[g*DIM+k] = t;
        end
        for (int k = 0; k < i; k++) begin
          t = lower_q[i*DIM+k];
          lower_q[i*DIM+k] = lower_q[g*DIM+k];
          lower_q[g*DIM+k] = t;
        end
        tp = perm_q[i];
        perm_q[i] = perm_q[g];
        perm_q[g] = tp;
      end
      piv = upper_q[i*DIM+i];
      for (int j = i + 1; j < n; j++) begin
        lead = upper_q[j*DIM+i];
        if (lead == 0 || piv == 0) begin
          lower_q[j*DIM+i] = 0;
        end else begin
          q = fx_div(lead, piv);
          lower_q[j*DIM+i] = q;
          upper_q[j*DIM+i] = 0;
          for (int k = i + 1; k < n; k++)
            upper_q[j*DIM+k] = clamp(66'(upper_q[j*DIM+k]) -
                                     66'(fx_mul(upper_q[i*DIM+k], q)));
        end
      end
    end
  endtask

  task automatic predict(input logic [1:0] f, input logic [1:0] sel,
                         input logic [3:0] r, input logic [3:0] c,
                         input logic [31:0] v);
    lu_result_t res;
    int n;
    n = dim_in_use();
    res = '0;
    case (f)
      FUNC_WRITE: begin
        if (r < n && c < n) begin
          upper_q[r*DIM+c] = v;
          written_q[r*DIM+c] = 1;
        end
      end
      FUNC_RUN: begin
        factor_matrix();
        res.status = 1'b1;
        expected_results.push_back(res);
      end
      FUNC_READ: begin
        if (r < n && c < n) begin
          case (sel)
            SEL_LOWER: res.value = lower_q[r*DIM+c];
            SEL_UPPER: res.value = upper_q[r*DIM+c];
            SEL_PERM:  res.value = (perm_q[r] == c) ? ONE_Q : '0;
            default:   res.value = '0;
          endcase
        end
        expected_results.push_back(res);
      end
      default: ;
    endcase
  endtask

  // Sends one transaction and waits for its acceptance.
  task automatic send_item(input logic [1:0] f, input logic [1:0] sel,
                           input logic [3:0] r, input logic [3:0] c,
                           input logic [31:0] v);
    func_i <= f;
    matrix_sel_i <= sel;
    row_index_i <= r;
    col_index_i <= c;
    entry_value_i <= v;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    predict(f, sel, r, c, v);
    @(negedge clk_i);
  endtask

  task automatic pause_input();
    in_valid_i <= 1'b0;
    repeat ($urandom_range(1, 6)) @(negedge clk_i);
  endtask

  // Random bursts with gaps between them.
  int burst_left = 0;
  task automatic send_paced(input logic [1:0] f, input logic [1:0] sel,
                            input logic [3:0] r, input logic [3:0] c,
                            input logic [31:0] v);
    if (burst_left == 0) begin
      if ($urandom_range(0, 2) != 0) pause_input();
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    send_item(f, sel, r, c, v);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic set_size(input logic [4:0] sz);
    drain();
    cfg_data_i <= sz;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    size_reg = sz;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] random_entry();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 16)) - 8) <<< 16;
      3: return '0;
      default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  task automatic load_matrix(input bit paced);
    int n;
    n = dim_in_use();
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++)
        if (paced) send_paced(FUNC_WRITE, SEL_LOWER, r, c, random_entry());
        else send_item(FUNC_WRITE, SEL_LOWER, r, c, random_entry());
  endtask

  task automatic read_random(input int count);
    logic [3:0] r, c;
    for (int i = 0; i < count; i++) begin
      r = $urandom;
      c = $urandom;
      // Never read a U entry that has not been written.
      if (!written_q[r*DIM+c] && r < dim_in_use() && c < dim_in_use()) begin
        r = $urandom_range(0, dim_in_use() - 1) % 2;
        c = 0;
      end
      send_paced(FUNC_READ, 2'($urandom_range(0, 3)), r, c, $urandom);
    end
  endtask

  task automatic test_small_extremes();
    set_size(5'd2);
    send_item(FUNC_WRITE, SEL_LOWER, 0, 0, 32'h8000_0000);
    send_item(FUNC_WRITE, SEL_LOWER, 0, 1, 32'h7FFF_FFFF);
    send_item(FUNC_WRITE, SEL_LOWER, 1, 0, 32'h7FFF_FFFF);
    send_item(FUNC_WRITE, SEL_LOWER, 1, 1, 32'h0000_0001);
    send_item(FUNC_WRITE, SEL_LOWER, 15, 15, 32'hFFFF_FFFF);
    send_item(FUNC_NOP, SEL_LOWER, 0, 0, 32'h1234_5678);
    send_item(FUNC_RUN, SEL_LOWER, 0, 0, 0);
    send_item(FUNC_READ, SEL_LOWER, 1, 0, 0);
    send_item(FUNC_READ, SEL_UPPER, 0, 0, 0);
    send_item(FUNC_READ, SEL_UPPER, 1, 1, 0);
    send_item(FUNC_READ, SEL_PERM, 0, 1, 0);
    send_item(FUNC_READ, SEL_NONE, 0, 0, 0);
    send_item(FUNC_READ, SEL_UPPER, 15, 15, 0);
    send_item(FUNC_RUN, SEL_LOWER, 0, 0, 0);
    send_item(FUNC_READ, SEL_UPPER, 0, 1, 0);
  endtask

  task automatic test_zero_pivot();
    set_size(5'd3);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        send_item(FUNC_WRITE, SEL_LOWER, r, c, (c == 0) ? 32'd0 : ONE_Q * (r + c));
    send_item(FUNC_RUN, SEL_LOWER, 0, 0, 0);
    for (int r = 0; r < 3; r++) send_item(FUNC_READ, SEL_LOWER, r, 0, 0);
  endtask

  task automatic test_random_sizes();
    logic [4:0] sizes [4] = '{5'd0, 5'd4, 5'd1, 5'd6};
    foreach (sizes[s]) begin
      set_size(sizes[s]);
      load_matrix(1);
      send_paced(FUNC_RUN, SEL_LOWER, 0, 0, 0);
      read_random(6);
    end
  endtask

  // The receiver holds off while the sender keeps offering reads.
  task automatic test_back_pressure();
    set_size(5'd3);
    load_matrix(0);
    send_item(FUNC_RUN, SEL_LOWER, 0, 0, 0);
    hold_off = 300;
    read_random(10);
    drain();
    read_random(10);
  endtask

  // A size above the largest matrix uses the largest matrix.
  task automatic test_size_clamp();
    set_size(5'd31);
    send_item(FUNC_WRITE, SEL_LOWER, 10, 12, 32'h0003_8000);
    send_item(FUNC_READ, SEL_UPPER, 10, 12, 0);
    send_item(FUNC_READ, SEL_LOWER, 15, 15, 0);
    send_item(FUNC_READ, SEL_LOWER, 15, 14, 0);
    send_item(FUNC_READ, SEL_PERM, 15, 15, 0);
    send_item(FUNC_READ, SEL_PERM, 14, 15, 0);
  endtask

  // Receiver stall pattern, with its own hold-off counter.
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    lu_result_t exp_r;
    cycle_count <= cycle_count + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        failed = 1;
        if (mismatches < 10)
          $display("Unexpected transaction: value %h status %b",
                   result_value_o, status_o);
        mismatches++;
      end else begin
        exp_r = expected_results.pop_front();
        if (exp_r.value !== result_value_o || exp_r.status !== status_o) begin
          failed = 1;
          if (mismatches < 10)
            $display("Mismatch: expected value %h status %b, got %h %b",
                     exp_r.value, exp_r.status, result_value_o, status_o);
          mismatches++;
        end
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    for (int a = 0; a < DIM*DIM; a++) begin
      upper_q[a] = 0;
      lower_q[a] = 0;
      written_q[a] = 0;
    end
    for (int a = 0; a < DIM; a++) perm_q[a] = a[3:0];
    size_reg = 5'd16;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_small_extremes();
    test_zero_pivot();
    test_random_sizes();
    test_back_pressure();
    stall_pct = 0;
    test_size_clamp();
    drain();
    if (failed || expected_results.size() != 0) begin
      $display("*** FAILED ***");
    end else begin
      $display("*** PASSED ***");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/ludpp_pkg.sv
design/ludpp_div.sv
design/ludpp_ctrl.sv
design/ludpp_dpath.sv
design/lu_decompose_partial_pivot_unit.sv
verif/lu_decompose_partial_pivot_unit_test.sv
